// ----- src/gcb_pkg.sv -----
package gcb_pkg;

  localparam int ANGLE_WIDTH   = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int NSTAGE = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // Datapath width: Q2.30 values plus growth headroom.
  localparam int DW = 36;
  localparam int AW = 34;

  localparam logic signed [DW-1:0] CORDIC_GAIN = DW'(652032874);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);
  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sd2147483648);
  localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_WIDTH);

  localparam int CFG_IW = 2;
  typedef enum logic [CFG_IW-1:0] {
    REG_GOAL_LAT   = 2'd0,
    REG_GOAL_LON   = 2'd1,
    REG_GOAL_VALID = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } fix_t;

  typedef struct packed {
    logic signed [31:0] bearing;
  } result_t;

  // One cell's data: x, y, residual angle.
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
  } cvec_t;

  function automatic logic signed [AW-1:0] atan_lut(input int i);
    logic signed [AW-1:0] r;
    begin
      unique case (i)
        0: r = AW'(536870912);  1: r = AW'(316933406);
        2: r = AW'(167458907);  3: r = AW'(85004756);
        4: r = AW'(42667331);   5: r = AW'(21354465);
        6: r = AW'(10679838);   7: r = AW'(5340245);
        8: r = AW'(2670163);    9: r = AW'(1335087);
        10: r = AW'(667544);    11: r = AW'(333772);
        12: r = AW'(166886);    13: r = AW'(83443);
        14: r = AW'(41722);     15: r = AW'(20861);
        16: r = AW'(10430);     17: r = AW'(5215);
        18: r = AW'(2608);      19: r = AW'(1304);
        20: r = AW'(652);       21: r = AW'(326);
        22: r = AW'(163);       23: r = AW'(81);
        24: r = AW'(41);        25: r = AW'(20);
        26: r = AW'(10);        27: r = AW'(5);
        28: r = AW'(3);         29: r = AW'(1);
        30: r = AW'(1);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/gcb_stream_if.sv -----
interface gcb_stream_if #(parameter int W = 64) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/gcb_cell.sv -----
// One CORDIC micro-rotation; rotation mode steers on z, vectoring mode on y.
module gcb_cell (
  input  logic               vector_mode,
  input  int                 shift,
  input  gcb_pkg::cvec_t     din,
  output gcb_pkg::cvec_t     dout
);
  import gcb_pkg::*;
  logic signed [DW-1:0] xs, ys;
  logic                 dir_pos;
  logic signed [AW-1:0] ang;

  always_comb begin
    xs = din.x >>> shift;
    ys = din.y >>> shift;
    ang = atan_lut(shift);
    dir_pos = vector_mode ? (din.y < 0) : (din.z >= 0);
    if (dir_pos) begin
      dout.x = din.x - ys;
      dout.y = din.y + xs;
      dout.z = vector_mode ? (din.z - ang) : (din.z - ang);
    end else begin
      dout.x = din.x + ys;
      dout.y = din.y - xs;
      dout.z = din.z + ang;
    end
  end
endmodule

// ----- src/gcb_chain.sv -----
// Row of CORDIC cells with a register per cell; a sideband bit rides along.
module gcb_chain (
  input  logic               clk,
  input  logic               vector_mode,
  input  logic               en,
  input  gcb_pkg::cvec_t     din,
  input  logic               sin,
  output gcb_pkg::cvec_t     dout,
  output logic               sout
);
  import gcb_pkg::*;
  cvec_t stage_r [NSTAGE+1];
  logic  side_r  [NSTAGE+1];

  always_comb begin
    stage_r[0] = din;
    side_r[0]  = sin;
  end

  for (genvar i = 0; i < NSTAGE; i++) begin : g_cell
    cvec_t c_nxt;
    cvec_t c_r;
    logic  s_r;
    gcb_cell u_cell (.vector_mode(vector_mode), .shift(i), .din(stage_r[i]), .dout(c_nxt));
    always_ff @(posedge clk) begin
      if (en) begin
        c_r <= c_nxt;
        s_r <= side_r[i];
      end
    end
    always_comb begin
      stage_r[i+1] = c_r;
      side_r[i+1]  = s_r;
    end
  end

  assign dout = stage_r[NSTAGE];
  assign sout = side_r[NSTAGE];
endmodule

// ----- src/great_circle_initial_bearing.sv -----
// Throughput: one fix per cycle; the whole pipeline advances when the output stage is free.
// Fixes taken while no goal is valid produce no result beat.
// Reset (rst_n low, synchronous): goal registers clear, all valid bits in the pipe clear.
// The pipe is three parallel rows of CORDIC cells (sine/cosine), then one atan2 row, with product stages between.
module great_circle_initial_bearing (
  input  logic                              clk,
  input  logic                              rst_n,
  gcb_stream_if.sink                        in_fix,
  gcb_stream_if.source                      out_res,
  input  logic                              cfg_we,
  input  logic [gcb_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [31:0]                       cfg_wdata
);
  import gcb_pkg::*;

  localparam int LAT = 2 * NSTAGE + 5;

  logic signed [31:0] dest_lat_r, dest_lon_r;
  logic               goal_valid_r;
  logic [LAT-1:0]     vld_r;
  logic               en;
  fix_t               fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_lat_r   <= '0;
      dest_lon_r   <= '0;
      goal_valid_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GOAL_LAT:   dest_lat_r   <= cfg_wdata;
        REG_GOAL_LON:   dest_lon_r   <= cfg_wdata;
        REG_GOAL_VALID: goal_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline stalls only when a finished beat waits at the output.
  assign en = !(out_res.valid && !out_res.ready);
  assign in_fix.ready = en;
  assign fix = in_fix.data;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_fix.valid && goal_valid_r};
  end

  // Stage 0: masked angles, quadrant fold for three sin/cos evaluations.
  logic [31:0] a_ang [3];
  cvec_t       rin [3];
  logic [2:0]  neg_nxt;

  always_comb begin
    a_ang[0] = 32'(fix.lat) & ANGLE_MASK;
    a_ang[1] = 32'(dest_lat_r) & ANGLE_MASK;
    a_ang[2] = (32'(dest_lon_r) & ANGLE_MASK) - (32'(fix.lon) & ANGLE_MASK);
    for (int k = 0; k < 3; k++) begin
      logic signed [AW-1:0] z;
      z = AW'($signed(a_ang[k]));
      neg_nxt[k] = 1'b0;
      if (z > QUARTER_TURN) begin
        z = z - HALF_TURN; neg_nxt[k] = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z = z + HALF_TURN; neg_nxt[k] = 1'b1;
      end
      rin[k].x = CORDIC_GAIN;
      rin[k].y = '0;
      rin[k].z = z;
    end
  end

  cvec_t      rin_r [3];
  logic [2:0] neg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rin_r <= rin;
      neg_r <= neg_nxt;
    end
  end

  cvec_t      rout [3];
  logic [2:0] negd;
  for (genvar k = 0; k < 3; k++) begin : g_sc
    gcb_chain u_sc (
      .clk(clk), .vector_mode(1'b0), .en(en), .din(rin_r[k]), .sin(neg_r[k]),
      .dout(rout[k]), .sout(negd[k]));
  end

  // Products; the first register stage holds three multiplies, and p_d is formed from its outputs.
  logic signed [DW-1:0] s1, c1, s2, c2, sd, cd;
  assign s1 = negd[0] ? -rout[0].y : rout[0].y;
  assign c1 = negd[0] ? -rout[0].x : rout[0].x;
  assign s2 = negd[1] ? -rout[1].y : rout[1].y;
  assign c2 = negd[1] ? -rout[1].x : rout[1].x;
  assign sd = negd[2] ? -rout[2].y : rout[2].y;
  assign cd = negd[2] ? -rout[2].x : rout[2].x;

  logic signed [2*DW-1:0] p_a, p_b, p_c, p_d;
  logic signed [DW-1:0]   a_r, b1_r, t_r, cd_r, a2_r, b1b_r, pd_r, b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= DW'(p_a >>> 30);
      b1_r  <= DW'(p_b >>> 30);
      t_r   <= DW'(p_c >>> 30);
      cd_r  <= cd;
      a2_r  <= a_r;
      b1b_r <= b1_r;
      pd_r  <= DW'(p_d >>> 30);
      b_r   <= b1b_r - pd_r;
    end
  end
  assign p_a = sd * c2;
  assign p_b = c1 * s2;
  assign p_c = s1 * c2;
  logic signed [DW-1:0] a3_r;
  always_ff @(posedge clk) if (en) a3_r <= a2_r;
  // p_d uses t_r and cd_r, registered one stage earlier.
  assign p_d = t_r * cd_r;

  // atan2 pre-rotation toward positive x.
  cvec_t vin;
  logic  nul;
  always_comb begin
    nul = (a3_r == 0) && (b_r == 0);
    vin.x = b_r; vin.y = a3_r; vin.z = '0;
    if (b_r < 0) begin
      if (a3_r >= 0) begin
        vin.x = a3_r; vin.y = -b_r; vin.z = QUARTER_TURN;
      end else begin
        vin.x = -a3_r; vin.y = b_r; vin.z = -QUARTER_TURN;
      end
    end
  end

  cvec_t vin_r, vout;
  logic  nul_r, nuld;
  always_ff @(posedge clk) begin
    if (en) begin
      vin_r <= vin;
      nul_r <= nul;
    end
  end

  gcb_chain u_at (
    .clk(clk), .vector_mode(1'b1), .en(en), .din(vin_r), .sin(nul_r),
    .dout(vout), .sout(nuld));

  result_t res;
  assign res.bearing = nuld ? '0 : ($signed(vout.z[31:0] & ANGLE_MASK));
  assign out_res.valid = vld_r[LAT-1];
  assign out_res.data  = res;

  ast_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.data))
    else $error("result changed while stalled");
  ast_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_fix.ready == !(out_res.valid && !out_res.ready))
    else $error("input ready mismatch");
  ast_novalid_goal: assert property (@(posedge clk) disable iff (!rst_n)
    in_fix.valid && in_fix.ready && !goal_valid_r |=> !vld_r[0])
    else $error("fix entered without goal");
endmodule
